/* src/rotation_matrix_to_quaternion_defines.svh */
// Assertion macros for the rotation matrix to quaternion block.
// Used by the top level; depends on nothing else.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RMQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RMQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/rmq_pkg.sv */
// Shared types and constants for the rotation matrix to quaternion block.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package rmq_pkg;

  // Width of a branch numerator: sum or difference of two 16-bit elements.
  localparam int NUM_W = 17;
  // Quotient bits computed by the divider chain; anything larger saturates.
  localparam int Q_BITS = 17;

  typedef enum logic [1:0] {
    BR_W = 2'd0,
    BR_X = 2'd1,
    BR_Y = 2'd2,
    BR_Z = 2'd3
  } branch_t;

  typedef struct packed {
    logic signed [15:0] elem_r1c1;
    logic signed [15:0] elem_r1c2;
    logic signed [15:0] elem_r1c3;
    logic signed [15:0] elem_r2c1;
    logic signed [15:0] elem_r2c2;
    logic signed [15:0] elem_r2c3;
    logic signed [15:0] elem_r3c1;
    logic signed [15:0] elem_r3c2;
    logic signed [15:0] elem_r3c3;
  } mat_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               bad_input;
  } quat_t;

  // Side data carried along the square root chain.
  typedef struct packed {
    logic                   bad;
    branch_t                branch;
    logic signed [NUM_W-1:0] n0;
    logic signed [NUM_W-1:0] n1;
    logic signed [NUM_W-1:0] n2;
  } pre_t;

  // Side data carried along the divider chain.
  typedef struct packed {
    logic               bad;
    branch_t            branch;
    logic signed [15:0] dom;
  } post_t;

endpackage

`default_nettype wire

/* src/rmq_sqrt_cell.sv */
// One cell of the square root chain: settles one root bit per cycle.
// Depends on rmq_pkg.
`default_nettype none

module rmq_sqrt_cell #(
  parameter int SQ = 17
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [2*SQ-1:0]   in_rad,
  input  wire logic [SQ+1:0]     in_rem,
  input  wire logic [SQ-1:0]     in_root,
  input  wire rmq_pkg::pre_t     in_side,
  output logic                   out_valid,
  output logic [2*SQ-1:0]        out_rad,
  output logic [SQ+1:0]          out_rem,
  output logic [SQ-1:0]          out_root,
  output rmq_pkg::pre_t          out_side
);
  import rmq_pkg::*;

  logic [SQ+3:0] rem_sh;
  logic [SQ+3:0] trial;
  logic          take;

  // Bring in the next two radicand bits and try root*4+1.
  assign rem_sh = {in_rem, in_rad[2*SQ-1 -: 2]};
  assign trial  = {2'b00, in_root, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rad  <= {in_rad[2*SQ-3:0], 2'b00};
    out_rem  <= take ? (SQ+2)'(rem_sh - trial) : rem_sh[SQ+1:0];
    out_root <= {in_root[SQ-2:0], take};
    out_side <= in_side;
  end

endmodule

`default_nettype wire

/* src/rmq_div_cell.sv */
// One cell of the divider chain: settles quotient bit K of three lanes.
// Depends on rmq_pkg.
`default_nettype none

module rmq_div_cell #(
  parameter int K  = 0,
  parameter int SQ = 17,
  parameter int CW = 50
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic [SQ:0]                         in_den,
  input  wire logic [2:0][CW-1:0]                  in_rem,
  input  wire logic [2:0][rmq_pkg::Q_BITS-1:0]     in_q,
  input  wire rmq_pkg::post_t                      in_side,
  input  wire logic [2:0]                          in_neg,
  input  wire logic [2:0]                          in_ovf,
  output logic                                     out_valid,
  output logic [SQ:0]                              out_den,
  output logic [2:0][CW-1:0]                       out_rem,
  output logic [2:0][rmq_pkg::Q_BITS-1:0]          out_q,
  output rmq_pkg::post_t                           out_side,
  output logic [2:0]                               out_neg,
  output logic [2:0]                               out_ovf
);
  import rmq_pkg::*;

  logic [CW-1:0] trial;

  assign trial = CW'(in_den) << K;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_den  <= in_den;
    out_side <= in_side;
    out_neg  <= in_neg;
    out_ovf  <= in_ovf;
    for (int l = 0; l < 3; l++) begin
      if (in_rem[l] >= trial) begin
        out_rem[l]  <= in_rem[l] - trial;
        out_q[l]    <= in_q[l] | (Q_BITS'(1) << K);
      end else begin
        out_rem[l]  <= in_rem[l];
        out_q[l]    <= in_q[l];
      end
    end
  end

endmodule

`default_nettype wire

/* src/rotation_matrix_to_quaternion.sv */
// Top level of the rotation matrix to quaternion block (Shepperd's method).
// Depends on rmq_pkg, rmq_sqrt_cell, rmq_div_cell and the defines header.
//
//   channel   ports               beat marker           who waits
//   matrix    matrix (mat_t)      start high, busy low  sender, while busy
//   quat      quat (quat_t)       done, one cycle       nobody
//
// A matrix beat may enter in every cycle while busy is low; results leave
// in order, one per accepted beat. Between acceptance and result lie one
// front stage, one cell per root bit of the square root chain, one
// divider setup stage, one cell per quotient bit of the divider chain and
// one output stage. Reset is synchronous and clears only the valid bits
// of the chains. busy is high only during reset; the receiver cannot
// stall, so nothing ever backs up.
`default_nettype none

module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire rmq_pkg::mat_t matrix,
  output logic               done,
  output rmq_pkg::quat_t     quat
);
  import rmq_pkg::*;

  `include "rotation_matrix_to_quaternion_defines.svh"

  // Signed radicand width, the shifted radicand width and root bits.
  localparam int RW   = ((FRAC_BITS > 18) ? FRAC_BITS : 18) + 2;
  localparam int SW   = RW - 1 + FRAC_BITS;
  localparam int SQ   = (SW + 1) / 2;
  // Dividend width and compare width of the divider chain.
  localparam int NW   = NUM_W + FRAC_BITS;
  localparam int CW   = ((NW > SQ + Q_BITS + 1) ? NW : SQ + Q_BITS + 1) + 1;
  localparam int DW   = (SQ > 16) ? SQ : 16;

  assign busy = rst;

  // Front stage: pick the branch, form the radicand and the numerators.
  logic signed [17:0]   trace;
  logic signed [RW-1:0] rad;
  logic signed [RW-1:0] one;
  pre_t                 pre_next;
  logic                 front_valid;
  pre_t                 front_side;
  logic [2*SQ-1:0]      front_rad;
  logic [2*SQ-1:0]      rad_sh_next;

  assign one = RW'(1) <<< FRAC_BITS;

  always_comb begin
    trace = 18'(matrix.elem_r1c1) + 18'(matrix.elem_r2c2) + 18'(matrix.elem_r3c3);
    if (trace > 18'sd0) begin
      pre_next.branch = BR_W;
      rad = one + RW'(trace);
      pre_next.n0 = NUM_W'(matrix.elem_r2c3) - NUM_W'(matrix.elem_r3c2);
      pre_next.n1 = NUM_W'(matrix.elem_r3c1) - NUM_W'(matrix.elem_r1c3);
      pre_next.n2 = NUM_W'(matrix.elem_r1c2) - NUM_W'(matrix.elem_r2c1);
    end else if (matrix.elem_r1c1 > matrix.elem_r2c2 &&
                 matrix.elem_r1c1 > matrix.elem_r3c3) begin
      pre_next.branch = BR_X;
      rad = one + RW'(matrix.elem_r1c1) - RW'(matrix.elem_r2c2) - RW'(matrix.elem_r3c3);
      pre_next.n0 = NUM_W'(matrix.elem_r1c2) + NUM_W'(matrix.elem_r2c1);
      pre_next.n1 = NUM_W'(matrix.elem_r1c3) + NUM_W'(matrix.elem_r3c1);
      pre_next.n2 = NUM_W'(matrix.elem_r2c3) - NUM_W'(matrix.elem_r3c2);
    end else if (matrix.elem_r2c2 > matrix.elem_r3c3) begin
      pre_next.branch = BR_Y;
      rad = one + RW'(matrix.elem_r2c2) - RW'(matrix.elem_r1c1) - RW'(matrix.elem_r3c3);
      pre_next.n0 = NUM_W'(matrix.elem_r2c1) + NUM_W'(matrix.elem_r1c2);
      pre_next.n1 = NUM_W'(matrix.elem_r3c2) + NUM_W'(matrix.elem_r2c3);
      pre_next.n2 = NUM_W'(matrix.elem_r3c1) - NUM_W'(matrix.elem_r1c3);
    end else begin
      pre_next.branch = BR_Z;
      rad = one + RW'(matrix.elem_r3c3) - RW'(matrix.elem_r1c1) - RW'(matrix.elem_r2c2);
      pre_next.n0 = NUM_W'(matrix.elem_r3c1) + NUM_W'(matrix.elem_r1c3);
      pre_next.n1 = NUM_W'(matrix.elem_r3c2) + NUM_W'(matrix.elem_r2c3);
      pre_next.n2 = NUM_W'(matrix.elem_r1c2) - NUM_W'(matrix.elem_r2c1);
    end
    pre_next.bad = (rad <= RW'(0));
    // A non-positive radicand is replaced by zero; its result is forced anyway.
    rad_sh_next = pre_next.bad ? '0 : ((2*SQ)'(rad[RW-2:0]) << FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else begin
      front_valid <= start && !busy;
    end
    front_side <= pre_next;
    front_rad  <= rad_sh_next;
  end

  // Square root chain: one cell per root bit.
  logic            sq_valid [SQ+1];
  logic [2*SQ-1:0] sq_rad   [SQ+1];
  logic [SQ+1:0]   sq_rem   [SQ+1];
  logic [SQ-1:0]   sq_root  [SQ+1];
  pre_t            sq_side  [SQ+1];

  assign sq_valid[0] = front_valid;
  assign sq_rad[0]   = front_rad;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = front_side;

  for (genvar i = 0; i < SQ; i++) begin : g_sqrt
    rmq_sqrt_cell #(.SQ(SQ)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sq_valid[i]),
      .in_rad   (sq_rad[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_side  (sq_side[i]),
      .out_valid(sq_valid[i+1]),
      .out_rad  (sq_rad[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_side (sq_side[i+1])
    );
  end

  // Divider setup: den = 4 * (root >> 1), dividends |n| << FRAC_BITS and
  // an overflow check for quotients beyond the computed bits.
  logic [SQ-1:0]              root;
  logic [DW-1:0]              dom_ext;
  logic [SQ:0]                den_next;
  logic [CW-1:0]              den_top;
  logic [2:0][NUM_W-1:0]      nums;
  logic [2:0][CW-1:0]         dvd_next;
  logic [2:0]                 neg_next;
  logic [2:0]                 ovf_next;
  post_t                      post_next;

  assign root    = sq_root[SQ];
  assign dom_ext = DW'(root >> 1);
  assign den_next = {root[SQ-1:1], 2'b00};
  assign den_top  = CW'(den_next) << Q_BITS;
  assign nums     = {sq_side[SQ].n2, sq_side[SQ].n1, sq_side[SQ].n0};

  always_comb begin
    post_next.bad    = sq_side[SQ].bad || (root < SQ'(2));
    post_next.branch = sq_side[SQ].branch;
    post_next.dom    = (dom_ext > DW'(32767)) ? 16'sd32767 : dom_ext[15:0];
    for (int l = 0; l < 3; l++) begin
      neg_next[l] = nums[l][NUM_W-1];
      dvd_next[l] = CW'(neg_next[l] ? (NUM_W)'(-nums[l]) : nums[l]) << FRAC_BITS;
      ovf_next[l] = (dvd_next[l] >= den_top);
    end
  end

  logic                         dv_valid [Q_BITS+1];
  logic [SQ:0]                  dv_den   [Q_BITS+1];
  logic [2:0][CW-1:0]           dv_rem   [Q_BITS+1];
  logic [2:0][Q_BITS-1:0]       dv_q     [Q_BITS+1];
  post_t                        dv_side  [Q_BITS+1];
  logic [2:0]                   dv_neg   [Q_BITS+1];
  logic [2:0]                   dv_ovf   [Q_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else begin
      dv_valid[0] <= sq_valid[SQ];
    end
    dv_den[0]  <= den_next;
    dv_rem[0]  <= dvd_next;
    dv_q[0]    <= '0;
    dv_side[0] <= post_next;
    dv_neg[0]  <= neg_next;
    dv_ovf[0]  <= ovf_next;
  end

  // Divider chain: cell j settles quotient bit Q_BITS-1-j of all lanes.
  for (genvar j = 0; j < Q_BITS; j++) begin : g_div
    rmq_div_cell #(.K(Q_BITS - 1 - j), .SQ(SQ), .CW(CW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (dv_valid[j]),
      .in_den   (dv_den[j]),
      .in_rem   (dv_rem[j]),
      .in_q     (dv_q[j]),
      .in_side  (dv_side[j]),
      .in_neg   (dv_neg[j]),
      .in_ovf   (dv_ovf[j]),
      .out_valid(dv_valid[j+1]),
      .out_den  (dv_den[j+1]),
      .out_rem  (dv_rem[j+1]),
      .out_q    (dv_q[j+1]),
      .out_side (dv_side[j+1]),
      .out_neg  (dv_neg[j+1]),
      .out_ovf  (dv_ovf[j+1])
    );
  end

  // Output stage: sign, saturate and place the components by branch.
  logic signed [2:0][15:0] comp;
  post_t                   fin;
  quat_t                   quat_next;

  assign fin = dv_side[Q_BITS];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv_neg[Q_BITS][l]) begin
        if (dv_ovf[Q_BITS][l] || dv_q[Q_BITS][l] > Q_BITS'(32768)) begin
          comp[l] = -16'sd32768;
        end else begin
          comp[l] = 16'(-dv_q[Q_BITS][l]);
        end
      end else begin
        if (dv_ovf[Q_BITS][l] || dv_q[Q_BITS][l] > Q_BITS'(32767)) begin
          comp[l] = 16'sd32767;
        end else begin
          comp[l] = dv_q[Q_BITS][l][15:0];
        end
      end
    end
    quat_next = '0;
    quat_next.bad_input = fin.bad;
    if (!fin.bad) begin
      case (fin.branch)
        BR_W: begin
          quat_next.quat_w = fin.dom;
          quat_next.quat_x = comp[0];
          quat_next.quat_y = comp[1];
          quat_next.quat_z = comp[2];
        end
        BR_X: begin
          quat_next.quat_x = fin.dom;
          quat_next.quat_y = comp[0];
          quat_next.quat_z = comp[1];
          quat_next.quat_w = comp[2];
        end
        BR_Y: begin
          quat_next.quat_y = fin.dom;
          quat_next.quat_x = comp[0];
          quat_next.quat_z = comp[1];
          quat_next.quat_w = comp[2];
        end
        default: begin
          quat_next.quat_z = fin.dom;
          quat_next.quat_x = comp[0];
          quat_next.quat_y = comp[1];
          quat_next.quat_w = comp[2];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid[Q_BITS];
    end
    quat <= quat_next;
  end

  // Summaries of the output beat and of the setup stage used by the checks.
  logic quat_all_zero;
  logic quat_any_pos;
  logic setup_ovf;

  assign quat_all_zero = (quat.quat_x == 16'sd0) && (quat.quat_y == 16'sd0) &&
                         (quat.quat_z == 16'sd0) && (quat.quat_w == 16'sd0);
  assign quat_any_pos  = (quat.quat_x > 16'sd0) || (quat.quat_y > 16'sd0) ||
                         (quat.quat_z > 16'sd0) || (quat.quat_w > 16'sd0);
  assign setup_ovf     = dv_valid[0] && (dv_ovf[0] == 3'b111) && !dv_side[0].bad;

  // A flagged result carries zeros in every component.
  `RMQ_ASSERT_NOW(a_bad_zero, clk, rst, done && quat.bad_input, quat_all_zero, "flagged result is not zero")
  // A good result has a positive dominant component somewhere.
  `RMQ_ASSERT_NOW(a_dom_pos, clk, rst, done && !quat.bad_input, quat_any_pos, "no positive component")
  // The chains keep their length: the last divider cell feeds done.
  `RMQ_ASSERT_NEXT(a_out_follows, clk, rst, dv_valid[Q_BITS], done, "divider output lost")
  // A setup-stage overflow survives to the output of the first divider cell.
  `RMQ_ASSERT_NEXT(a_ovf_kept, clk, rst, setup_ovf, dv_ovf[1] == 3'b111 && dv_valid[1], "overflow dropped")

endmodule

`default_nettype wire

/* tb/sv/rotation_matrix_to_quaternion_tb.sv */
// Self-checking bench for the rotation matrix to quaternion block.
// Depends on rmq_pkg and rotation_matrix_to_quaternion; drives matrix beats
// and compares each quaternion beat with an in-bench computation.
`default_nettype none

module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int FRAC = 14;
  localparam int LAT = 37;
  localparam int N_RANDOM = 1250;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic signed [15:0] ONE_Q = 16'sd16384;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  mat_t matrix = '0;
  quat_t quat;

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .matrix(matrix), .done(done), .quat(quat)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Matrices waiting to be sent, and quaternions expected back in order.
  mat_t pending_mats[$];
  quat_t expected_quats[$];
  int mismatches = 0;
  int quats_seen = 0;
  int bad_seen = 0;
  int branch_hits[4] = '{0, 0, 0, 0};
  longint cycle_count = 0;
  bit hold_sender = 1'b0;

  // Floor square root of a non-negative value, bit by bit.
  function automatic longint floor_sqrt(longint x);
    longint res;
    longint b;
    res = 0;
    b = longint'(1) << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Which component dominates, by the same test as the block.
  function automatic branch_t branch_of(mat_t m);
    longint tr;
    tr = longint'(m.elem_r1c1) + longint'(m.elem_r2c2) + longint'(m.elem_r3c3);
    if (tr > 0) return BR_W;
    if (m.elem_r1c1 > m.elem_r2c2 && m.elem_r1c1 > m.elem_r3c3) return BR_X;
    if (m.elem_r2c2 > m.elem_r3c3) return BR_Y;
    return BR_Z;
  endfunction

  // Shepperd's method in fixed point: choose the dominant component, take
  // its root, and divide the three off-diagonal combinations by 4*dom.
  function automatic quat_t quat_of(mat_t m);
    longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
    longint tr, rad, n0, n1, n2, dom, den;
    logic signed [15:0] c0, c1, c2, d;
    branch_t br;
    quat_t q;
    a11 = m.elem_r1c1; a12 = m.elem_r1c2; a13 = m.elem_r1c3;
    a21 = m.elem_r2c1; a22 = m.elem_r2c2; a23 = m.elem_r2c3;
    a31 = m.elem_r3c1; a32 = m.elem_r3c2; a33 = m.elem_r3c3;
    q = '0;
    tr = a11 + a22 + a33;
    if (tr > 0) begin
      br = BR_W; rad = (longint'(1) << FRAC) + tr;
      n0 = a23 - a32; n1 = a31 - a13; n2 = a12 - a21;
    end else if (a11 > a22 && a11 > a33) begin
      br = BR_X; rad = (longint'(1) << FRAC) + a11 - a22 - a33;
      n0 = a12 + a21; n1 = a13 + a31; n2 = a23 - a32;
    end else if (a22 > a33) begin
      br = BR_Y; rad = (longint'(1) << FRAC) + a22 - a11 - a33;
      n0 = a21 + a12; n1 = a32 + a23; n2 = a31 - a13;
    end else begin
      br = BR_Z; rad = (longint'(1) << FRAC) + a33 - a11 - a22;
      n0 = a31 + a13; n1 = a32 + a23; n2 = a12 - a21;
    end
    if (rad <= 0) begin
      q.bad_input = 1'b1;
      return q;
    end
    dom = floor_sqrt(rad << FRAC) >> 1;
    den = 4 * dom;
    if (den <= 0) begin
      q.bad_input = 1'b1;
      return q;
    end
    // SystemVerilog division truncates toward zero, like the block, which divides magnitudes.
    c0 = clamp16((n0 << FRAC) / den);
    c1 = clamp16((n1 << FRAC) / den);
    c2 = clamp16((n2 << FRAC) / den);
    d = clamp16(dom);
    case (br)
      BR_W: begin q.quat_w = d; q.quat_x = c0; q.quat_y = c1; q.quat_z = c2; end
      BR_X: begin q.quat_x = d; q.quat_y = c0; q.quat_z = c1; q.quat_w = c2; end
      BR_Y: begin q.quat_y = d; q.quat_x = c0; q.quat_z = c1; q.quat_w = c2; end
      default: begin q.quat_z = d; q.quat_x = c0; q.quat_y = c1; q.quat_w = c2; end
    endcase
    return q;
  endfunction

  function automatic mat_t diag_mat(logic signed [15:0] d1, logic signed [15:0] d2,
                                    logic signed [15:0] d3);
    mat_t m;
    m = '0;
    m.elem_r1c1 = d1; m.elem_r2c2 = d2; m.elem_r3c3 = d3;
    return m;
  endfunction

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3, 4: return 16'($signed($urandom_range(0, 32768)) - 16384);
      5, 6: return 16'($signed($urandom_range(0, 4000)) - 2000);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly matrices with a redrawn random diagonal, often with one non-negative
  // element, so that every branch is reached; the rest is raw noise.
  function automatic mat_t rand_mat();
    mat_t m;
    int pick;
    m.elem_r1c1 = rand_elem(); m.elem_r1c2 = rand_elem(); m.elem_r1c3 = rand_elem();
    m.elem_r2c1 = rand_elem(); m.elem_r2c2 = rand_elem(); m.elem_r2c3 = rand_elem();
    m.elem_r3c1 = rand_elem(); m.elem_r3c2 = rand_elem(); m.elem_r3c3 = rand_elem();
    if ($urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, 3);
      m.elem_r1c1 = 16'($signed($urandom_range(0, 32768)) - 16384);
      m.elem_r2c2 = 16'($signed($urandom_range(0, 32768)) - 16384);
      m.elem_r3c3 = 16'($signed($urandom_range(0, 32768)) - 16384);
      if (pick == 1) m.elem_r1c1 = 16'($urandom_range(0, 16384));
      if (pick == 2) m.elem_r2c2 = 16'($urandom_range(0, 16384));
      if (pick == 3) m.elem_r3c3 = 16'($urandom_range(0, 16384));
    end
    return m;
  endfunction

  // Driver: bursts of beats separated by random gaps. A beat leaves the
  // queue only at an edge where the block took it.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_quats.push_back(quat_of(pending_mats.pop_front()));
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_mats.size() != 0 && !hold_sender &&
                   !(start && !busy && pending_mats.size() == 0)) begin
        start <= 1'b1;
        matrix <= pending_mats[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each done beat is compared with the oldest expectation.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected quaternion beat %p", quat);
      end else begin
        quat_t want;
        want = expected_quats.pop_front();
        quats_seen++;
        if (want.bad_input) bad_seen++;
        if (quat !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on beat %0d: expected %p, got %p", quats_seen, want, quat);
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    mat_t m;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed matrices: identity, the three half-turns (one per branch),
    // diagonal ties, extreme elements, matrices with every element equal and
    // a near-zero diagonal under large off-diagonal elements.
    pending_mats.push_back(diag_mat(ONE_Q, ONE_Q, ONE_Q));
    pending_mats.push_back(diag_mat(ONE_Q, -ONE_Q, -ONE_Q));
    pending_mats.push_back(diag_mat(-ONE_Q, ONE_Q, -ONE_Q));
    pending_mats.push_back(diag_mat(-ONE_Q, -ONE_Q, ONE_Q));
    pending_mats.push_back(diag_mat(-16'sd100, -16'sd100, -16'sd100));
    pending_mats.push_back(diag_mat(16'sd0, 16'sd0, 16'sd0));
    pending_mats.push_back(diag_mat(16'sh8000, 16'sh7fff, 16'sh7fff));
    pending_mats.push_back(diag_mat(16'sh7fff, 16'sh8000, 16'sh8000));
    pending_mats.push_back(diag_mat(16'sh8000, 16'sh8000, 16'sh8000));
    pending_mats.push_back(diag_mat(-ONE_Q, 16'sd0, ONE_Q));
    pending_mats.push_back(diag_mat(-16'sd8192, -16'sd8192, 16'sd0));
    pending_mats.push_back(diag_mat(-16'sd16383, 16'sd0, 16'sd0));
    pending_mats.push_back(diag_mat(-16'sd16384, 16'sd0, 16'sd0));
    m = {9{16'sh7fff}};
    pending_mats.push_back(m);
    m = {9{16'sh8000}};
    pending_mats.push_back(m);
    m = diag_mat(16'sd0, 16'sd0, 16'sd1);
    m.elem_r1c2 = 16'sh7fff; m.elem_r2c1 = 16'sh8000;
    m.elem_r2c3 = 16'sh7fff; m.elem_r3c2 = 16'sh8000;
    pending_mats.push_back(m);
    m = diag_mat(-16'sd16383, -16'sd16383, 16'sd16383);
    m.elem_r1c3 = 16'sh7fff; m.elem_r3c1 = 16'sh7fff;
    pending_mats.push_back(m);
    m = {9{16'hffff}};
    pending_mats.push_back(m);
    m = {9{16'h5555}};
    pending_mats.push_back(m);
    m = {9{16'haaaa}};
    pending_mats.push_back(m);

    // Let the directed beats drain fully before the random part.
    wait (pending_mats.size() == 0);
    @(posedge clk);
    hold_sender = 1'b1;
    wait (expected_quats.size() == 0);
    @(posedge clk);
    hold_sender = 1'b0;

    for (int i = 0; i < N_RANDOM; i++) begin
      m = rand_mat();
      pending_mats.push_back(m);
      branch_hits[branch_of(m)]++;
      if (i == N_RANDOM / 2) begin
        wait (pending_mats.size() == 0);
        @(posedge clk);
      end
    end
    wait (pending_mats.size() == 0);
    @(posedge clk);
    @(posedge clk);
    wait (expected_quats.size() == 0);
    repeat (LAT + 10) @(posedge clk);
    $display("covered %0d quaternion beats, %0d flagged as bad input", quats_seen, bad_seen);
    $display("random beats led by w %0d, x %0d, y %0d, z %0d; bursts, gaps and a full drain",
             branch_hits[BR_W], branch_hits[BR_X], branch_hits[BR_Y], branch_hits[BR_Z]);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* rotation_matrix_to_quaternion.f */
+incdir+src
src/rmq_pkg.sv
src/rmq_sqrt_cell.sv
src/rmq_div_cell.sv
src/rotation_matrix_to_quaternion.sv
tb/sv/rotation_matrix_to_quaternion_tb.sv
